@@ rtl/b2dt_pkg.sv @@
// Package for the binary to decimal text converter.
// Holds the controller state type, the cell control struct and shared constants.
// No dependencies.
package b2dt_pkg;

  // Width of one BCD digit held in a cell.
  localparam int DIGIT_W = 4;

  // ASCII code of '0', cut to the width of the digit_char port.
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_EMIT
  } b2dt_state_t;

  // Control broadcast to every cell of the digit chain.
  typedef struct packed {
    logic clear;        // zero the digit
    logic dabble;       // add-3 correction, then shift in one binary bit
    logic shift_digit;  // take the whole digit of the lower neighbor
  } cell_ctrl_t;

endpackage

@@ rtl/b2dt_cell.sv @@
// One BCD digit cell of the double dabble chain.
// Depends on b2dt_pkg for DIGIT_W and cell_ctrl_t.
module b2dt_cell
  import b2dt_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               carry_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               carry_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] adj;

  // Add 3 when the digit would pass 9 after doubling.
  always_comb begin
    if (digit >= DIGIT_W'(5)) begin
      adj = digit + DIGIT_W'(3);
    end else begin
      adj = digit;
    end
  end

  assign carry_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[DIGIT_W-2:0], carry_in};
    end else if (ctrl.shift_digit) begin
      digit <= digit_in;
    end
  end

endmodule

@@ rtl/binary_to_decimal_text.sv @@
// Binary to decimal text converter, top level.
// Depends on b2dt_pkg and b2dt_cell.
//
// Takes one unsigned value per transaction (only the low VALUE_BITS bits
// count) and returns its decimal digits as ASCII characters '0'..'9', most
// significant first, one output transaction per digit, with leading zeros
// dropped; zero gives a single '0'. The last digit of a value has last = 1.
// Conversion runs on a chain of NUM_DIGITS BCD cells by shift-and-add-3:
// each convert cycle the input shift register hands its top bit to the
// lowest cell and every cell passes its carry to the next one up, for
// VALUE_BITS bits. The same chain then moves digits up one cell per cycle
// toward the output register whenever that register is free: a leading zero
// is dropped, a shown digit is loaded into the output register. A new value
// is not taken until emission ends, as the single cell chain is used for
// both conversion and emission. in_ready is high only while the chain is
// idle, but the last digit of the previous value may still wait in the
// output register while the next value is taken in.
module binary_to_decimal_text
  import b2dt_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  digit_char,
  output logic        last
);

  // Decimal digits of 2**VALUE_BITS - 1 (floor(n * log10 2) + 1).
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCNT_W     = $clog2(VALUE_BITS + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  b2dt_state_t state, state_next;

  logic [VALUE_BITS-1:0] sreg;        // bits still to feed, MSB first
  logic [BCNT_W-1:0]     bit_cnt;     // bits left to feed
  logic [REM_W-1:0]      remaining;   // digits left in the chain
  logic                  started;     // a digit has been shown

  logic in_accept;
  logic emit_step;
  logic emit_show;

  cell_ctrl_t ctrl;

  logic               carry [NUM_DIGITS];
  logic [DIGIT_W-1:0] digit [NUM_DIGITS];
  logic [DIGIT_W-1:0] top_digit;

  assign in_accept = in_valid && in_ready;
  assign top_digit = digit[NUM_DIGITS-1];

  // Advance the chain in emit whenever the output register can take a digit.
  assign emit_step = (state == S_EMIT) && (!out_valid || out_ready);
  // Show the top digit unless it is a leading zero; the final digit always shows.
  assign emit_show = started || (top_digit != '0) || (remaining == REM_W'(1));

  // ---------------------------------------------------------------- cell chain
  assign carry[0] = sreg[VALUE_BITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      b2dt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i]),
        .digit_in  ('0),
        .carry_out (carry[i+1]),
        .digit     (digit[i])
      );
    end else if (i == NUM_DIGITS - 1) begin : g_top
      b2dt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i]),
        .digit_in  (digit[i-1]),
        .carry_out (),
        .digit     (digit[i])
      );
    end else begin : g_mid
      b2dt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i]),
        .digit_in  (digit[i-1]),
        .carry_out (carry[i+1]),
        .digit     (digit[i])
      );
    end
  end

  // ---------------------------------------------------------------- controller
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_CONVERT;
      end
      S_CONVERT: begin
        if (bit_cnt == BCNT_W'(1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_step && (remaining == REM_W'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    ctrl.clear       = 1'b0;
    ctrl.dabble      = 1'b0;
    ctrl.shift_digit = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctrl.clear = in_valid;
      end
      S_CONVERT: begin
        ctrl.dabble = 1'b1;
      end
      S_EMIT: begin
        ctrl.shift_digit = emit_step;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input shift register: load on accept, advance one bit per convert cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sreg <= value[VALUE_BITS-1:0];
    end else if (state == S_CONVERT) begin
      sreg <= {sreg[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt   <= '0;
      remaining <= '0;
      started   <= 1'b0;
    end else begin
      if (in_accept) begin
        bit_cnt <= BCNT_W'(VALUE_BITS);
        started <= 1'b0;
      end else if (state == S_CONVERT) begin
        bit_cnt <= bit_cnt - BCNT_W'(1);
      end
      if ((state == S_CONVERT) && (bit_cnt == BCNT_W'(1))) begin
        remaining <= REM_W'(NUM_DIGITS);
      end else if (emit_step) begin
        remaining <= remaining - REM_W'(1);
        if (emit_show) started <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_step && emit_show) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_step && emit_show) begin
      digit_char <= ASCII_ZERO + {2'b00, top_digit};
      last       <= (remaining == REM_W'(1));
    end
  end

endmodule
